>>> hdl/event_fifo_with_id_search_top_macros.svh
// Assertion helpers for the event FIFO controller.
`ifndef EVENT_FIFO_WITH_ID_SEARCH_TOP_MACROS_SVH
`define EVENT_FIFO_WITH_ID_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EFS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define EFS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/efs_pkg.sv
// ----------------------------------------------------------------------------
// efs_pkg
// Shared types and constants for the event FIFO with ID search.
// ----------------------------------------------------------------------------
package efs_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ACT_W    = 2;
  localparam int STATE_W  = 4;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ZEROID   = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming word
    logic match;  // register per-cell compare results
    logic exec;   // apply the operation and write the result register
  } efs_cmd_t;

endpackage

>>> hdl/event_fifo_with_id_search_top.sv
// ----------------------------------------------------------------------------
// event_fifo_with_id_search_top
// Bounded FIFO of (event state, node ID) entries with ID membership check.
// ----------------------------------------------------------------------------
// Each input word is push, pop or check (tuser: 0 push, 1 pop, other check)
// and gives exactly one result word. An item goes through three steps: capture,
// a compare pass where every entry cell checks its ID against the operand,
// and the update that writes the result register. The result register lets
// the next word be accepted while a result waits; the update of that next
// word waits until the pending result is taken. Status codes: 0 pushed,
// 1 full, 2 popped, 3 empty, 4 found, 5 not found, 6 zero ID rejected.
module event_fifo_with_id_search_top
  import efs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // event_state[3:0], node_id[19:4], zero pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // removed_state[3:0], removed_id[19:4],
                                 // occupancy[24:20], zero pad
  output logic [2:0]  m_tuser    // status[2:0]
);

  efs_cmd_t            cmd;
  logic [STATE_W-1:0]  removed_state;
  logic [ID_W-1:0]     removed_id;
  logic [OCC_W-1:0]    occupancy;
  logic [STATUS_W-1:0] status;

  efs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  efs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (s_tuser),
    .event_state   (s_tdata[3:0]),
    .node_id       (s_tdata[19:4]),
    .status        (status),
    .removed_state (removed_state),
    .removed_id    (removed_id),
    .occupancy     (occupancy)
  );

  assign m_tuser = status;
  assign m_tdata = {7'd0, occupancy, removed_id, removed_state};

endmodule

>>> hdl/efs_ctrl.sv
// ----------------------------------------------------------------------------
// efs_ctrl
// Sequencer: accept, compare, update; owns the result valid flag.
// ----------------------------------------------------------------------------
`include "event_fifo_with_id_search_top_macros.svh"

module efs_ctrl
  import efs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output efs_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        exec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // update only once the previous result word has left
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign exec_stall = (state == S_EXEC) && out_valid && !out_ready;

  `EFS_ASSERT_NXT(a_accept_to_match, clk, rst, in_valid && in_ready, state == S_MATCH)
  `EFS_ASSERT_NXT(a_match_to_exec, clk, rst, state == S_MATCH, state == S_EXEC)
  `EFS_ASSERT_NXT(a_exec_stall, clk, rst, exec_stall, state == S_EXEC && out_valid)
  `EFS_ASSERT_IMP(a_exec_free, clk, rst, cmd.exec, !out_valid || out_ready)

endmodule

>>> hdl/efs_datapath.sv
// ----------------------------------------------------------------------------
// efs_datapath
// Shift-register entry cells with a comparator each, count and result regs.
// Cell 0 is the newest entry, cell count-1 the oldest.
// ----------------------------------------------------------------------------
module efs_datapath
  import efs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  efs_cmd_t            cmd,
  input  logic [ACT_W-1:0]    action,
  input  logic [STATE_W-1:0]  event_state,
  input  logic [ID_W-1:0]     node_id,
  output logic [STATUS_W-1:0] status,
  output logic [STATE_W-1:0]  removed_state,
  output logic [ID_W-1:0]     removed_id,
  output logic [OCC_W-1:0]    occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [STATE_W-1:0] cell_state [DEPTH];
  logic [ID_W-1:0]    cell_id    [DEPTH];
  logic [CW-1:0]      count;

  logic [ACT_W-1:0]   op_act;
  logic [STATE_W-1:0] op_state;
  logic [ID_W-1:0]    op_id;

  logic [DEPTH-1:0]   hit_vec;
  logic [DEPTH-1:0]   old_vec;

  logic [STATE_W-1:0] old_state;
  logic [ID_W-1:0]    old_id;
  logic               do_push;
  logic               do_pop;

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_act   <= action;
      op_state <= event_state;
      op_id    <= node_id;
    end
  end

  // per-cell compare and oldest-cell select
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int k = 0; k < DEPTH; k++) begin
        hit_vec[k] <= (cell_id[k] == op_id) && (CW'(k) < count);
        old_vec[k] <= (CW'(k) == count - 1'b1);
      end
    end
  end

  always_comb begin
    old_state = '0;
    old_id    = '0;
    for (int k = 0; k < DEPTH; k++) begin
      old_state = old_state | (cell_state[k] & {STATE_W{old_vec[k]}});
      old_id    = old_id | (cell_id[k] & {ID_W{old_vec[k]}});
    end
  end

  assign do_push = cmd.exec && (op_act == ACT_PUSH) && (count != DEPTH_C) && (op_id != '0);
  assign do_pop  = cmd.exec && (op_act == ACT_POP) && (count != '0);

  // cells beyond count are never observed, so they need no reset or clearing
  always_ff @(posedge clk) begin
    if (do_push) begin
      cell_state[0] <= op_state;
      cell_id[0]    <= op_id;
      for (int k = 1; k < DEPTH; k++) begin
        cell_state[k] <= cell_state[k-1];
        cell_id[k]    <= cell_id[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_push) begin
      count <= count + 1'b1;
    end else if (do_pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      removed_state <= '0;
      removed_id    <= '0;
      priority if (op_act == ACT_PUSH) begin
        if (count == DEPTH_C) begin
          status <= ST_FULL;
        end else if (op_id == '0) begin
          status <= ST_ZEROID;
        end else begin
          status <= ST_PUSHED;
        end
      end else if (op_act == ACT_POP) begin
        if (count == '0) begin
          status <= ST_EMPTY;
        end else begin
          status        <= ST_POPPED;
          removed_state <= old_state;
          removed_id    <= old_id;
        end
      end else begin
        status <= (|hit_vec) ? ST_FOUND : ST_NOTFOUND;
      end
    end
  end

  // count only moves on exec, which waits for the previous word to leave
  assign occupancy = OCC_W'(count);

endmodule
